@@ rtl/tisf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tape image stream framer package
// Shared types, byte codes and record constants for the framer front end,
// command queue and record generator.
// ----------------------------------------------------------------------------
package tisf_pkg;

  // Default depth of the command queue between front and back (power of two).
  localparam int QUEUE_DEPTH_DEF = 4;

  // Parser phases of the front end.
  typedef enum logic [3:0] {
    PH_MARKER    = 4'd0,
    PH_LEN1      = 4'd1,
    PH_LEN2      = 4'd2,
    PH_OUTER     = 4'd3,
    PH_SIZE1     = 4'd4,
    PH_SIZE2     = 4'd5,
    PH_TTYPE     = 4'd6,
    PH_TINDEX    = 4'd7,
    PH_TINDEXBAD = 4'd8,
    PH_ADDRL     = 4'd9,
    PH_ADDRH     = 4'd10,
    PH_COUNT     = 4'd11,
    PH_PAYLOAD   = 4'd12,
    PH_DONE      = 4'd13,
    PH_HALT      = 4'd14
  } phase_t;

  // Class of the inner block, picked from its type byte.
  typedef enum logic [1:0] {
    CLS_NAME  = 2'd0,
    CLS_DATA  = 2'd1,
    CLS_CLOSE = 2'd2,
    CLS_AUTO  = 2'd3
  } inner_class_t;

  // Image byte codes.
  localparam logic [7:0] BYTE_MARKER    = 8'hFF;
  localparam logic [7:0] BYTE_BLOCK     = 8'h55;
  localparam logic [7:0] BYTE_LAST_BLK  = 8'hAA;
  localparam logic [7:0] BYTE_SYNC      = 8'hAA;
  localparam logic [7:0] BYTE_LEAD      = 8'hFF;
  localparam logic [7:0] BYTE_HDR_MARK  = 8'hD3;

  // Record kinds on the output.
  localparam logic [1:0] REC_SILENCE = 2'd0;
  localparam logic [1:0] REC_BYTE    = 2'd1;
  localparam logic [1:0] REC_ERROR   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MARKER = 2'd1;
  localparam logic [1:0] ERR_OUTER  = 2'd2;
  localparam logic [1:0] ERR_INNER  = 2'd3;

  // Run lengths.
  localparam logic [10:0] CNT_ONE     = 11'd1;
  localparam logic [10:0] CNT_SILENCE = 11'd2000;
  localparam logic [10:0] CNT_SYNC    = 11'd512;
  localparam logic [10:0] CNT_LEAD    = 11'd96;
  localparam logic [10:0] CNT_HDR     = 11'd3;

  // Command codes passed from front to back; each expands to one or two records.
  typedef enum logic [2:0] {
    CMD_ERROR     = 3'd0,  // one error record
    CMD_BYTE      = 3'd1,  // one tape byte, repeated once
    CMD_LEADER    = 3'd2,  // silence run, then sync bytes
    CMD_BLOCK_HDR = 3'd3,  // lead bytes, then header marks
    CMD_BAD_INDEX = 3'd4   // index byte, then inner type error
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  value;
    logic [1:0]  err;
    logic        eoi;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [10:0] count;
    logic [1:0]  err;
    logic        eoi;
    logic        last;
  } rec_t;

endpackage
`default_nettype wire

@@ rtl/tisf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Framer front end
// Parses the tape image one byte at a time and turns the bytes into
// commands for the record generator.
// ----------------------------------------------------------------------------
module tisf_front import tisf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] image_byte,
  output logic            push,
  output cmd_t            cmd
);

  phase_t       phase_r, phase_nxt;
  logic [8:0]   rem_r, rem_nxt;
  logic         final_r, final_nxt;
  inner_class_t cls_r, cls_nxt;

  logic [8:0]   rem_dec;
  logic         pay_end;
  logic         type_ok;
  inner_class_t type_cls;
  logic [8:0]   count_len;

  assign rem_dec   = (rem_r != 9'd0) ? (rem_r - 9'd1) : 9'd0;
  assign pay_end   = (rem_dec == 9'd0);
  // A count byte of zero stands for 256; one more byte carries the checksum.
  assign count_len = (image_byte == 8'd0) ? 9'd257 : ({1'b0, image_byte} + 9'd1);

  always_comb begin
    type_ok  = 1'b1;
    type_cls = CLS_NAME;
    case (image_byte) inside
      8'h83, 8'h87:               type_cls = CLS_NAME;
      8'hF1, 8'hF5, 8'hF7, 8'hF9: type_cls = CLS_DATA;
      8'hB1, 8'hB5, 8'hB7:        type_cls = CLS_CLOSE;
      8'hB9:                      type_cls = CLS_AUTO;
      default:                    type_ok  = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    final_nxt = final_r;
    cls_nxt   = cls_r;
    if (take) begin
      case (phase_r)
        PH_MARKER: phase_nxt = (image_byte == BYTE_MARKER) ? PH_LEN1 : PH_HALT;
        PH_LEN1:   phase_nxt = PH_LEN2;
        PH_LEN2:   phase_nxt = PH_OUTER;
        PH_OUTER: begin
          if (image_byte == BYTE_BLOCK || image_byte == BYTE_LAST_BLK) begin
            final_nxt = (image_byte == BYTE_LAST_BLK);
            phase_nxt = PH_SIZE1;
          end else begin
            phase_nxt = PH_HALT;
          end
        end
        PH_SIZE1: phase_nxt = PH_SIZE2;
        PH_SIZE2: phase_nxt = PH_TTYPE;
        PH_TTYPE: begin
          if (type_ok) begin
            cls_nxt   = type_cls;
            phase_nxt = PH_TINDEX;
          end else begin
            phase_nxt = PH_TINDEXBAD;
          end
        end
        PH_TINDEXBAD: phase_nxt = PH_HALT;
        PH_TINDEX: begin
          case (cls_r)
            CLS_NAME: phase_nxt = PH_COUNT;
            CLS_DATA: phase_nxt = PH_ADDRL;
            CLS_AUTO: begin
              rem_nxt   = 9'd3;
              phase_nxt = PH_PAYLOAD;
            end
            default: begin
              rem_nxt   = 9'd1;
              phase_nxt = PH_PAYLOAD;
            end
          endcase
        end
        PH_ADDRL: phase_nxt = PH_ADDRH;
        PH_ADDRH: phase_nxt = PH_COUNT;
        PH_COUNT: begin
          rem_nxt   = count_len;
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_dec;
          if (pay_end) begin
            phase_nxt = final_r ? PH_DONE : PH_OUTER;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Command output.
  always_comb begin
    push      = 1'b0;
    cmd.kind  = CMD_BYTE;
    cmd.value = image_byte;
    cmd.err   = ERR_NONE;
    cmd.eoi   = 1'b0;
    if (take) begin
      case (phase_r)
        PH_MARKER: begin
          if (image_byte != BYTE_MARKER) begin
            push     = 1'b1;
            cmd.kind = CMD_ERROR;
            cmd.err  = ERR_MARKER;
          end
        end
        PH_LEN2: begin
          push     = 1'b1;
          cmd.kind = CMD_LEADER;
        end
        PH_OUTER: begin
          push = 1'b1;
          if (image_byte == BYTE_BLOCK || image_byte == BYTE_LAST_BLK) begin
            cmd.kind = CMD_BLOCK_HDR;
          end else begin
            cmd.kind = CMD_ERROR;
            cmd.err  = ERR_OUTER;
          end
        end
        PH_TTYPE, PH_TINDEX, PH_ADDRL, PH_ADDRH, PH_COUNT: begin
          push = 1'b1;
        end
        PH_TINDEXBAD: begin
          push     = 1'b1;
          cmd.kind = CMD_BAD_INDEX;
        end
        PH_PAYLOAD: begin
          push    = 1'b1;
          cmd.eoi = pay_end & final_r;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MARKER;
      rem_r   <= 9'd0;
      final_r <= 1'b0;
      cls_r   <= CLS_NAME;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      final_r <= final_nxt;
      cls_r   <= cls_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tisf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer that decouples the parser from the
// record generator.
// ----------------------------------------------------------------------------
module tisf_queue import tisf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + AW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? (rd_ptr_r + AW'(1)) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count exceeds its depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue fill count did not follow a push");

endmodule
`default_nettype wire

@@ rtl/tisf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Record generator
// Expands queued commands into one or two output records and holds the
// current record in the output register.
// ----------------------------------------------------------------------------
module tisf_back import tisf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  cmd_t      head,
  output logic      pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output rec_t      out_rec
);

  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;
  logic second_r, second_nxt;
  cmd_t held_r, held_nxt;
  logic out_free;

  function automatic logic has_two(input cmd_t c);
    return (c.kind == CMD_LEADER) || (c.kind == CMD_BLOCK_HDR) ||
           (c.kind == CMD_BAD_INDEX);
  endfunction

  function automatic rec_t first_rec(input cmd_t c);
    rec_t r;
    r = '{kind: REC_BYTE, value: c.value, count: CNT_ONE, err: ERR_NONE,
          eoi: c.eoi, last: 1'b1};
    case (c.kind)
      CMD_ERROR:     r = '{REC_ERROR, 8'd0, 11'd0, c.err, 1'b0, 1'b1};
      CMD_LEADER:    r = '{REC_SILENCE, 8'd0, CNT_SILENCE, ERR_NONE, 1'b0, 1'b0};
      CMD_BLOCK_HDR: r = '{REC_BYTE, BYTE_LEAD, CNT_LEAD, ERR_NONE, 1'b0, 1'b0};
      CMD_BAD_INDEX: r = '{REC_BYTE, c.value, CNT_ONE, ERR_NONE, 1'b0, 1'b0};
      default:       r.last = 1'b1;
    endcase
    return r;
  endfunction

  function automatic rec_t second_rec(input cmd_t c);
    rec_t r;
    r = '{REC_ERROR, 8'd0, 11'd0, ERR_INNER, 1'b0, 1'b1};
    case (c.kind)
      CMD_LEADER:    r = '{REC_BYTE, BYTE_SYNC, CNT_SYNC, ERR_NONE, 1'b0, 1'b1};
      CMD_BLOCK_HDR: r = '{REC_BYTE, BYTE_HDR_MARK, CNT_HDR, ERR_NONE, 1'b0, 1'b1};
      default:       r.last = 1'b1;
    endcase
    return r;
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = out_free && !second_r && head_valid;
  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rec_nxt   = out_rec_r;
    second_nxt    = second_r;
    held_nxt      = held_r;
    if (out_free) begin
      out_valid_nxt = second_r || head_valid;
      if (second_r) begin
        out_rec_nxt = second_rec(held_r);
        second_nxt  = 1'b0;
      end else if (head_valid) begin
        out_rec_nxt = first_rec(head);
        second_nxt  = has_two(head);
        held_nxt    = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
    held_r    <= held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      second_r    <= second_nxt;
    end
  end

  a_second_kind: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (held_r.kind == CMD_LEADER || held_r.kind == CMD_BLOCK_HDR ||
                  held_r.kind == CMD_BAD_INDEX))
    else $error("second record pending for a single-record command");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rec_r.kind == REC_ERROR) |-> out_rec_r.last)
    else $error("error record not marked as last");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (second_r && out_free) |=> (out_valid_r && out_rec_r.last && !second_r))
    else $error("second record did not follow its first");

endmodule
`default_nettype wire

@@ rtl/tape_image_stream_framer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Tape image stream framer
// Turns a tape image byte stream into silence and repeated-byte records.
// ----------------------------------------------------------------------------
// The block takes one image byte per request on the input channel and emits
// tape run records on the output channel. An input byte is taken in every
// cycle while the command queue has room, so a steady stream of copied block
// bytes runs at one byte and one record per cycle while the output is not
// stalled. The file marker, the first file length byte and both block size
// bytes emit nothing. The second file length byte, every valid outer block
// type byte and the index byte after a bad inner block type emit two
// records, which pass in turn through the record generator's single output
// register. The command queue (QUEUE_DEPTH entries) absorbs these bursts so
// the input is not stalled by them. When the output is not stalled, the
// command for a byte is written into the command queue, and its first record
// is then held in the output register, from which it is valid on the output.
// A bad file marker, a bad outer block type or a bad inner block type ends
// with an error record, after which further bytes are taken and ignored;
// the same holds after the final byte of the last block, which carries
// end_of_image.
// ----------------------------------------------------------------------------
module tape_image_stream_framer import tisf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel: image bytes.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_image_byte,
  // Output channel: tape run records.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_record_kind,
  output logic [7:0]       out_byte_value,
  output logic [10:0]      out_repeat_count,
  output logic [1:0]       out_error_code,
  output logic             out_end_of_image,
  output logic             out_last
);

  logic take;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic full;
  logic head_valid;
  cmd_t head;
  rec_t out_rec;

  // A request is taken whenever the queue can hold whatever it produces.
  assign in_stall = full;
  assign take     = in_valid && !full;

  tisf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .image_byte (in_image_byte),
    .push       (push),
    .cmd        (push_cmd)
  );

  tisf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  tisf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_rec    (out_rec)
  );

  assign out_record_kind  = out_rec.kind;
  assign out_byte_value   = out_rec.value;
  assign out_repeat_count = out_rec.count;
  assign out_error_code   = out_rec.err;
  assign out_end_of_image = out_rec.eoi;
  assign out_last         = out_rec.last;

endmodule
`default_nettype wire
